### sv/fnpll_pkg.sv
package fnpll_pkg;

    // Field and datapath widths fixed by the interface.
    localparam int LO_W      = 33;
    localparam int REF_W     = 27;
    localparam int DEN_W     = 29;
    localparam int N_W       = 8;
    localparam int NLO_W     = 3;
    localparam int FRAC24_W  = 24;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [NLO_W-1:0] NLO_MAX      = 3'd7;
    localparam logic [LO_W-1:0]  VCO_SPLIT_HZ = 33'd3200000000;
    localparam logic [REF_W-1:0] REF_RESET    = 27'd26000000;
    localparam logic [LO_W-1:0]  LO_MAX_RESET = 33'd5400000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LO_MAX   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_FBK,
        ST_DIVGO,
        ST_DIVW,
        ST_MUL,
        ST_DONE
    } t_state;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

### sv/fnpll_div.sv
module fnpll_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fnpll_pkg::t_div_ctrl               i_ctrl,
    input  logic [fnpll_pkg::LO_W-1:0]         i_dividend,
    input  logic [fnpll_pkg::DEN_W-1:0]        i_divisor,
    output fnpll_pkg::t_div_stat               o_stat,
    output logic [fnpll_pkg::N_W-1:0]          o_q_int,
    output logic [FRAC_BITS-1:0]               o_q_frac
);

    // Restoring division of dividend * 2^FRAC_BITS, one quotient bit per cycle.
    localparam int QW    = fnpll_pkg::LO_W + FRAC_BITS;
    localparam int QK    = fnpll_pkg::N_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    logic [QW-1:0]                 r_dvd;
    logic [fnpll_pkg::DEN_W-1:0]   r_rem;
    logic [QK-1:0]                 r_quo;
    logic                          r_ovf;
    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;

    logic [fnpll_pkg::DEN_W:0]     w_trial;
    logic [fnpll_pkg::DEN_W:0]     w_diff;
    logic                          w_qbit;

    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_qbit  = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dvd <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_rem <= w_qbit ? w_diff[fnpll_pkg::DEN_W-1:0] : w_trial[fnpll_pkg::DEN_W-1:0];
            r_quo <= {r_quo[QK-2:0], w_qbit};
            // Any quotient bit pushed past the integer byte means the integer saturates.
            r_ovf <= r_ovf | r_quo[QK-1];
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_q_int     = r_quo[QK-1:FRAC_BITS];
    assign o_q_frac    = r_quo[FRAC_BITS-1:0];

endmodule

### sv/frac_n_pll_divider_calc.sv
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+---------------------------------
// request   | in        | i_in_valid / o_in_stall        | i_lo_freq_hz
// result    | out       | o_out_valid / i_out_stall      | o_skipped .. o_tuned_hz
// config    | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// A computed request runs the divider exponent search, the feedback divider choice,
// the bit-serial divider and the multiply before its result is loaded. Repeated
// and out-of-range requests go straight to the output register.
// One request is in work at a time; o_in_stall is high from transfer until the
// result sits in the output register, which may still be waiting on i_out_stall.
// Reset is synchronous and active low; it restores the default reference and
// maximum VCO frequency and clears the remembered request to zero.
module frac_n_pll_divider_calc #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [fnpll_pkg::LO_W-1:0]           i_lo_freq_hz,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_skipped,
    output logic                                 o_range_error,
    output logic [fnpll_pkg::NLO_W-1:0]          o_lo_div_exp,
    output logic                                 o_fbk_div_four,
    output logic [fnpll_pkg::N_W-1:0]            o_n_integer,
    output logic [15:0]                          o_frac_high,
    output logic [7:0]                           o_frac_low,
    output logic [fnpll_pkg::WORD_W-1:0]         o_freq_word,
    output logic [fnpll_pkg::LO_W-1:0]           o_tuned_hz,
    // Configuration channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fnpll_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fnpll_pkg::LO_W-1:0]           i_cfg_data
);

    localparam int PROD_W = fnpll_pkg::DEN_W + fnpll_pkg::N_W + fnpll_pkg::FRAC24_W;

    fnpll_pkg::t_state r_state;
    fnpll_pkg::t_state n_state;

    // Configuration and remembered request.
    logic [fnpll_pkg::REF_W-1:0]   r_ref;
    logic [fnpll_pkg::LO_W-1:0]    r_lo_max;
    logic [fnpll_pkg::LO_W-1:0]    r_prev;

    // Working registers for the request in flight.
    logic [fnpll_pkg::LO_W-1:0]    r_lo;
    logic [fnpll_pkg::LO_W-1:0]    r_fvco;
    logic [fnpll_pkg::NLO_W-1:0]   r_nlo;
    logic                          r_skip;
    logic                          r_err;
    logic                          r_fbk4;
    logic [fnpll_pkg::DEN_W-1:0]   r_den;
    logic [fnpll_pkg::N_W-1:0]     r_n;
    logic [fnpll_pkg::FRAC24_W-1:0] r_frac24;
    logic [PROD_W-1:0]             r_prod;

    // Output register.
    logic                          r_out_valid;
    logic                          r_o_skipped;
    logic                          r_o_range_error;
    logic [fnpll_pkg::NLO_W-1:0]   r_o_lo_div_exp;
    logic                          r_o_fbk_div_four;
    logic [fnpll_pkg::N_W-1:0]     r_o_n_integer;
    logic [fnpll_pkg::FRAC24_W-1:0] r_o_frac24;
    logic [fnpll_pkg::WORD_W-1:0]  r_o_freq_word;
    logic [fnpll_pkg::LO_W-1:0]    r_o_tuned_hz;

    // Control decoded from the state.
    logic                          w_in_take;
    logic                          w_cfg_take;
    logic                          w_out_load;
    logic                          w_idle;

    logic                          w_new_skip;
    logic                          w_new_err;
    logic                          w_log_step;
    logic                          w_fbk4;
    logic [fnpll_pkg::REF_W-1:0]   w_ref;
    logic [PROD_W-1:0]             w_shifted;

    fnpll_pkg::t_div_ctrl          w_div_ctrl;
    fnpll_pkg::t_div_stat          w_div_stat;
    logic [fnpll_pkg::N_W-1:0]     w_q_int;
    logic [FRAC_BITS-1:0]          w_q_frac;

    fnpll_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (r_fvco),
        .i_divisor  (r_den),
        .o_stat     (w_div_stat),
        .o_q_int    (w_q_int),
        .o_q_frac   (w_q_frac)
    );

    // A repeat is checked before the range, so a zero request right after reset is a repeat.
    assign w_new_skip = (i_lo_freq_hz == r_prev);
    assign w_new_err  = (i_lo_freq_hz == '0) || (i_lo_freq_hz > r_lo_max);

    // The exponent grows while doubling the VCO frequency stays within the maximum;
    // this is floor(log2(lo_max / lo)), capped at NLO_MAX, without a divide.
    assign w_log_step = ({r_fvco, 1'b0} <= {1'b0, r_lo_max}) && (r_nlo != fnpll_pkg::NLO_MAX);

    assign w_fbk4 = (r_fvco > fnpll_pkg::VCO_SPLIT_HZ);
    assign w_ref  = (r_ref == '0) ? fnpll_pkg::REF_W'(1) : r_ref;

    // Tuned frequency: drop the 24 fraction bits and undo the output divider.
    assign w_shifted = r_prod >> (6'd24 + 6'(r_nlo));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fnpll_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (w_new_skip || w_new_err) ? fnpll_pkg::ST_DONE
                                                        : fnpll_pkg::ST_LOG;
                end
            end
            fnpll_pkg::ST_LOG: begin
                if (!w_log_step) begin
                    n_state = fnpll_pkg::ST_FBK;
                end
            end
            fnpll_pkg::ST_FBK:   n_state = fnpll_pkg::ST_DIVGO;
            fnpll_pkg::ST_DIVGO: n_state = fnpll_pkg::ST_DIVW;
            fnpll_pkg::ST_DIVW: begin
                if (w_div_stat.done) begin
                    n_state = fnpll_pkg::ST_MUL;
                end
            end
            fnpll_pkg::ST_MUL:   n_state = fnpll_pkg::ST_DONE;
            fnpll_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = fnpll_pkg::ST_IDLE;
                end
            end
            default:             n_state = fnpll_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_idle           = (r_state == fnpll_pkg::ST_IDLE);
        w_in_take        = w_idle && i_in_valid;
        w_cfg_take       = w_idle && i_cfg_valid;
        w_div_ctrl.start = (r_state == fnpll_pkg::ST_DIVGO);
        w_out_load       = (r_state == fnpll_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fnpll_pkg::ST_IDLE;
            r_ref       <= fnpll_pkg::REF_RESET;
            r_lo_max    <= fnpll_pkg::LO_MAX_RESET;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_take) begin
                unique case (i_cfg_index)
                    fnpll_pkg::CFG_REF_FREQ: r_ref    <= i_cfg_data[fnpll_pkg::REF_W-1:0];
                    fnpll_pkg::CFG_LO_MAX:   r_lo_max <= i_cfg_data;
                    default:                 r_ref    <= r_ref;
                endcase
            end
            // Only a request that was actually computed becomes the one to compare against.
            if (w_out_load && !r_skip && !r_err) begin
                r_prev <= r_lo;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_lo   <= i_lo_freq_hz;
            r_fvco <= i_lo_freq_hz;
            r_nlo  <= '0;
            r_skip <= w_new_skip;
            r_err  <= w_new_err;
        end
        if ((r_state == fnpll_pkg::ST_LOG) && w_log_step) begin
            r_fvco <= {r_fvco[fnpll_pkg::LO_W-2:0], 1'b0};
            r_nlo  <= r_nlo + 1'b1;
        end
        if (r_state == fnpll_pkg::ST_FBK) begin
            r_fbk4 <= w_fbk4;
            r_den  <= w_fbk4 ? {w_ref, 2'b00} : {1'b0, w_ref, 1'b0};
        end
        if ((r_state == fnpll_pkg::ST_DIVW) && w_div_stat.done) begin
            // An integer part above one byte saturates the whole ratio.
            if (w_div_stat.ovf) begin
                r_n      <= '1;
                r_frac24 <= '1;
            end else begin
                r_n      <= w_q_int;
                r_frac24 <= fnpll_pkg::FRAC24_W'(w_q_frac) << (fnpll_pkg::FRAC24_W - FRAC_BITS);
            end
        end
        if (r_state == fnpll_pkg::ST_MUL) begin
            r_prod <= PROD_W'(r_den) * PROD_W'({r_n, r_frac24});
        end
    end

    // Output register load.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_skipped      <= r_skip;
            r_o_range_error  <= r_err && !r_skip;
            if (r_skip || r_err) begin
                r_o_lo_div_exp   <= '0;
                r_o_fbk_div_four <= 1'b0;
                r_o_n_integer    <= '0;
                r_o_frac24       <= '0;
                r_o_freq_word    <= '0;
                r_o_tuned_hz     <= r_skip ? r_lo : '0;
            end else begin
                r_o_lo_div_exp   <= r_nlo;
                r_o_fbk_div_four <= r_fbk4;
                r_o_n_integer    <= r_n;
                r_o_frac24       <= r_frac24;
                // n at bit 7, exponent at bit 4, half the feedback divider at bit 2.
                r_o_freq_word    <= {1'b0, r_n, r_nlo, r_fbk4, !r_fbk4, 2'b00};
                r_o_tuned_hz     <= w_shifted[fnpll_pkg::LO_W-1:0];
            end
        end
    end

    assign o_in_stall     = !w_idle;
    assign o_cfg_ready    = w_idle;
    assign o_out_valid    = r_out_valid;
    assign o_skipped      = r_o_skipped;
    assign o_range_error  = r_o_range_error;
    assign o_lo_div_exp   = r_o_lo_div_exp;
    assign o_fbk_div_four = r_o_fbk_div_four;
    assign o_n_integer    = r_o_n_integer;
    assign o_frac_high    = r_o_frac24[23:8];
    assign o_frac_low     = r_o_frac24[7:0];
    assign o_freq_word    = r_o_freq_word;
    assign o_tuned_hz     = r_o_tuned_hz;

endmodule

### sv/fnpll_checker.sv
module fnpll_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic                              o_skipped,
    input  logic                              o_range_error,
    input  logic [fnpll_pkg::NLO_W-1:0]       o_lo_div_exp,
    input  logic                              o_fbk_div_four,
    input  logic [fnpll_pkg::N_W-1:0]         o_n_integer,
    input  logic [15:0]                       o_frac_high,
    input  logic [7:0]                        o_frac_low,
    input  logic [fnpll_pkg::WORD_W-1:0]      o_freq_word,
    input  logic [fnpll_pkg::LO_W-1:0]        o_tuned_hz
);

    // A stalled result stays valid and keeps its tuned frequency.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tuned_hz))
        else $error("result changed while stalled");

    // After a request transfer the block is busy with it.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request channel open right after a transfer");

    // A repeat reports no error and no settings.
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_skipped |-> !o_range_error && o_freq_word == '0 &&
        o_n_integer == '0 && o_frac_high == '0 && o_frac_low == '0 &&
        o_lo_div_exp == '0 && !o_fbk_div_four)
        else $error("skipped result carries settings");

    // An out-of-range request is no repeat and carries no tuned frequency, word or integer.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> !o_skipped && o_tuned_hz == '0 &&
        o_freq_word == '0 && o_n_integer == '0)
        else $error("range error result carries settings");

    // The frequency word packs the other settings.
    a_word_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_skipped && !o_range_error |->
        o_freq_word[15] == 1'b0 && o_freq_word[14:7] == o_n_integer &&
        o_freq_word[6:4] == o_lo_div_exp && o_freq_word[3] == o_fbk_div_four &&
        o_freq_word[2] == !o_fbk_div_four && o_freq_word[1:0] == 2'b00)
        else $error("frequency word does not match settings");

endmodule

bind frac_n_pll_divider_calc fnpll_checker u_fnpll_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the fractional-N divider calculator.
//
// A short table of directed requests runs first, with the reset settings.
// Then come phases of random requests; each but the first starts by loading a
// new reference and maximum VCO frequency through the configuration channel
// while the block is idle. Every accepted request is passed through the local
// tuning predictor, and the expected result is queued. The output monitor
// checks each result transfer field by field against the oldest queued entry.
module tb_top;

    localparam int FRAC_BITS   = 24;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int NUM_PHASES  = 10;
    localparam int MAX_IDLE    = 14;

    // One result as the block presents it, in port order.
    typedef struct packed {
        logic                          skipped;
        logic                          range_error;
        logic [fnpll_pkg::NLO_W-1:0]   lo_div_exp;
        logic                          fbk_div_four;
        logic [fnpll_pkg::N_W-1:0]     n_integer;
        logic [15:0]                   frac_high;
        logic [7:0]                    frac_low;
        logic [fnpll_pkg::WORD_W-1:0]  freq_word;
        logic [fnpll_pkg::LO_W-1:0]    tuned_hz;
    } t_tune_result;

    // A queued expectation keeps its request so that a mismatch can be traced.
    typedef struct packed {
        logic [fnpll_pkg::LO_W-1:0] lo;
        t_tune_result               want;
    } t_pending_tuning;

    // A row of the directed table. Where typed is set, the expected result is
    // the one written into the row; otherwise it comes from the predictor.
    typedef struct packed {
        logic [fnpll_pkg::LO_W-1:0] lo;
        logic                       typed;
        t_tune_result               want;
    } t_directed_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [fnpll_pkg::LO_W-1:0]        i_lo_freq_hz = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_skipped;
    logic                              o_range_error;
    logic [fnpll_pkg::NLO_W-1:0]       o_lo_div_exp;
    logic                              o_fbk_div_four;
    logic [fnpll_pkg::N_W-1:0]         o_n_integer;
    logic [15:0]                       o_frac_high;
    logic [7:0]                        o_frac_low;
    logic [fnpll_pkg::WORD_W-1:0]      o_freq_word;
    logic [fnpll_pkg::LO_W-1:0]        o_tuned_hz;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [fnpll_pkg::CFG_IDX_W-1:0]   i_cfg_index = fnpll_pkg::CFG_REF_FREQ;
    logic [fnpll_pkg::LO_W-1:0]        i_cfg_data = '0;

    // Predictor copy of the settings and of the remembered request.
    logic [fnpll_pkg::REF_W-1:0]       ref_hz_cfg = fnpll_pkg::REF_RESET;
    logic [fnpll_pkg::LO_W-1:0]        lo_max_cfg = fnpll_pkg::LO_MAX_RESET;
    logic [fnpll_pkg::LO_W-1:0]        last_lo = '0;

    t_pending_tuning       pending_tunings[$];
    t_directed_row         directed_rows[$];

    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    int                    stall_left = 0;
    // When low, neither side inserts idle cycles.
    bit                    idle_on = 1'b1;

    frac_n_pll_divider_calc #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_lo_freq_hz   (i_lo_freq_hz),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_skipped      (o_skipped),
        .o_range_error  (o_range_error),
        .o_lo_div_exp   (o_lo_div_exp),
        .o_fbk_div_four (o_fbk_div_four),
        .o_n_integer    (o_n_integer),
        .o_frac_high    (o_frac_high),
        .o_frac_low     (o_frac_low),
        .o_freq_word    (o_freq_word),
        .o_tuned_hz     (o_tuned_hz),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The run is bounded, so that a hung handshake cannot go on forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_tunings.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Computes the synthesizer settings for one request and updates the
    // remembered request the way the block does. All arithmetic is done in
    // 64 bits: the VCO frequency needs 40 bits, and the tuned frequency
    // product needs 61.
    function automatic t_tune_result compute_tuning(input logic [fnpll_pkg::LO_W-1:0] lo);
        t_tune_result res;
        logic [63:0]  ratio;
        logic [63:0]  vco_hz;
        logic [63:0]  ref_hz;
        logic [63:0]  den;
        logic [63:0]  n_div;
        logic [63:0]  rem;
        logic [63:0]  frac24;
        logic [63:0]  tuned;
        logic [63:0]  fbk;
        int unsigned  div_exp;

        res = '0;
        // A repeat is echoed, and nothing else is touched.
        if (lo == last_lo) begin
            res.skipped  = 1'b1;
            res.tuned_hz = lo;
            return res;
        end
        // Zero or above the top of the VCO range: only the error flag is set.
        if (lo == '0 || lo > lo_max_cfg) begin
            res.range_error = 1'b1;
            return res;
        end

        // The output divider exponent is floor(log2(lo_max / lo)), at most 7.
        ratio   = 64'(lo_max_cfg) / 64'(lo);
        div_exp = 0;
        while (ratio > 64'd1) begin
            ratio = ratio >> 1;
            div_exp++;
        end
        if (div_exp > 32'(fnpll_pkg::NLO_MAX))
            div_exp = 32'(fnpll_pkg::NLO_MAX);

        vco_hz = 64'(lo) << div_exp;
        fbk    = (vco_hz > 64'(fnpll_pkg::VCO_SPLIT_HZ)) ? 64'd4 : 64'd2;
        // A zero reference counts as 1 Hz.
        ref_hz = (ref_hz_cfg == '0) ? 64'd1 : 64'(ref_hz_cfg);
        den    = fbk * ref_hz;

        n_div = vco_hz / den;
        rem   = vco_hz % den;
        if (n_div > 64'd255) begin
            n_div  = 64'd255;
            frac24 = 64'hFF_FFFF;
        end else begin
            frac24 = (((rem << FRAC_BITS) / den) << (24 - FRAC_BITS)) & 64'hFF_FFFF;
        end

        // Truncating fixed-point product: den * (n.frac) / 2^exponent.
        tuned = (den * ((n_div << 24) | frac24)) >> (24 + div_exp);

        res.lo_div_exp   = fnpll_pkg::NLO_W'(div_exp);
        res.fbk_div_four = (fbk == 64'd4);
        res.n_integer    = fnpll_pkg::N_W'(n_div);
        res.frac_high    = frac24[23:8];
        res.frac_low     = frac24[7:0];
        res.freq_word    = fnpll_pkg::WORD_W'((n_div << 7) + (64'(div_exp) << 4) +
                                              ((fbk >> 1) << 2));
        res.tuned_hz     = fnpll_pkg::LO_W'(tuned);
        last_lo = lo;
        return res;
    endfunction

    function automatic t_tune_result skipped_result(input logic [fnpll_pkg::LO_W-1:0] lo);
        t_tune_result res;
        res          = '0;
        res.skipped  = 1'b1;
        res.tuned_hz = lo;
        return res;
    endfunction

    function automatic t_tune_result error_result();
        t_tune_result res;
        res             = '0;
        res.range_error = 1'b1;
        return res;
    endfunction

    // Draws a random request for the current settings. Most requests are in
    // range, some sit right at the boundaries where the divider exponent
    // changes, and the rest are repeats, zero, above range or unconstrained.
    function automatic logic [fnpll_pkg::LO_W-1:0] draw_request();
        logic [63:0] wide;
        int unsigned pick;
        int unsigned shift;

        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 55 && lo_max_cfg != '0)
            return fnpll_pkg::LO_W'(wide % 64'(lo_max_cfg)) + fnpll_pkg::LO_W'(1);
        if (pick < 70 && lo_max_cfg != '0) begin
            shift = $urandom_range(0, 9);
            return (lo_max_cfg >> shift) + fnpll_pkg::LO_W'($urandom_range(0, 2)) -
                   fnpll_pkg::LO_W'(1);
        end
        if (pick < 82)
            return last_lo;
        if (pick < 86)
            return '0;
        if (pick < 94)
            return lo_max_cfg + fnpll_pkg::LO_W'(1) + fnpll_pkg::LO_W'($urandom_range(0, 1000));
        return wide[fnpll_pkg::LO_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want,
                               input logic [fnpll_pkg::LO_W-1:0] lo);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d, request %0d Hz",
                                      name, got, want, lo));
    endtask

    // Sends one request after a random gap and queues its expected result once
    // the transfer has happened. The valid line is left high, so that a
    // following request with no gap keeps it up without a second assignment.
    task automatic send_request(input logic [fnpll_pkg::LO_W-1:0] lo, input logic typed,
                                input t_tune_result typed_want);
        int           gap;
        t_tune_result predicted;

        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_lo_freq_hz <= lo;
        do @(posedge i_clk); while (o_in_stall);
        // The predictor runs for typed rows too, to keep the remembered request.
        predicted = compute_tuning(lo);
        pending_tunings.push_back('{lo: lo, want: typed ? typed_want : predicted});
    endtask

    // Stops sending and waits until every queued result has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_tunings.size() != 0);
    endtask

    // Writes both settings registers. Each write is a transfer on the
    // configuration channel; the predictor takes the value as it goes in.
    task automatic load_settings(input logic [fnpll_pkg::LO_W-1:0] ref_data,
                                 input logic [fnpll_pkg::LO_W-1:0] lo_max);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fnpll_pkg::CFG_REF_FREQ;
        i_cfg_data  <= ref_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ref_hz_cfg = ref_data[fnpll_pkg::REF_W-1:0];
        i_cfg_index <= fnpll_pkg::CFG_LO_MAX;
        i_cfg_data  <= lo_max;
        do @(posedge i_clk); while (!o_cfg_ready);
        lo_max_cfg = lo_max;
        i_cfg_valid <= 1'b0;
    endtask

    // Result side stall. After each result transfer a new wait is drawn, and
    // while nothing is waiting a stall is sometimes started on its own, so
    // that stalls also cover the cycle at which a result first appears.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if (idle_on && !o_out_valid && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, MAX_IDLE);
        end
        i_out_stall <= (stall_left > 0);
    end

    // Output monitor: every result transfer is matched with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_pending_tuning head;
        t_tune_result    seen;

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_skipped, o_range_error, o_lo_div_exp, o_fbk_div_four, o_n_integer,
                    o_frac_high, o_frac_low, o_freq_word, o_tuned_hz};
            if (pending_tunings.size() == 0) begin
                report_mismatch($sformatf("result with no request outstanding, tuned %0d Hz",
                                          o_tuned_hz));
            end else begin
                head = pending_tunings.pop_front();
                check_field("skipped", 64'(seen.skipped), 64'(head.want.skipped), head.lo);
                check_field("range_error", 64'(seen.range_error),
                            64'(head.want.range_error), head.lo);
                check_field("lo_div_exp", 64'(seen.lo_div_exp),
                            64'(head.want.lo_div_exp), head.lo);
                check_field("fbk_div_four", 64'(seen.fbk_div_four),
                            64'(head.want.fbk_div_four), head.lo);
                check_field("n_integer", 64'(seen.n_integer),
                            64'(head.want.n_integer), head.lo);
                check_field("frac_high", 64'(seen.frac_high),
                            64'(head.want.frac_high), head.lo);
                check_field("frac_low", 64'(seen.frac_low),
                            64'(head.want.frac_low), head.lo);
                check_field("freq_word", 64'(seen.freq_word),
                            64'(head.want.freq_word), head.lo);
                check_field("tuned_hz", 64'(seen.tuned_hz),
                            64'(head.want.tuned_hz), head.lo);
            end
        end
    end

    // Main sequence.
    initial begin
        logic [fnpll_pkg::LO_W-1:0] phase_ref[NUM_PHASES];
        logic [fnpll_pkg::LO_W-1:0] phase_lo_max[NUM_PHASES];
        int                         phase_items[NUM_PHASES];
        bit                         phase_drawn[NUM_PHASES];
        t_directed_row              row;

        // Settings per phase. Phase 0 keeps the reset values. Drawn phases
        // pick a reference and a maximum inside the usual operating range.
        // Some others cover the register extremes: all ones, a zero reference
        // (which drives the integer divide into saturation), a low reference,
        // and a zero maximum that rejects every new request.
        phase_ref    = '{33'd0, 33'd10000000, 33'd104000000, 33'h1_FFFF_FFFF, 33'd0,
                         33'd3000000, 33'd0, 33'd26000000, 33'd0, 33'd26000000};
        phase_lo_max = '{33'd0, 33'd6000000000, 33'd1000000000, 33'h1_FFFF_FFFF,
                         33'd5400000000, 33'd2000000000, 33'd0, 33'd0, 33'd0,
                         33'd5400000000};
        phase_items  = '{200, 220, 220, 220, 200, 200, 220, 30, 220, 200};
        phase_drawn  = '{0, 0, 0, 0, 0, 0, 1, 0, 1, 0};

        // Directed requests under the reset settings. Typed rows are the
        // obvious cases: the zero request right after reset (a repeat of the
        // cleared remembered request), requests above the maximum or zero
        // (range errors), and repeats. The rest are checked by the predictor:
        // the request equal to the maximum, a 1 Hz request that saturates the
        // exponent, VCO frequencies just at and just above the 3.2 GHz split,
        // the exponent boundaries and an exact integer divide.
        directed_rows.push_back('{lo: 33'd0, typed: 1'b1, want: skipped_result(33'd0)});
        directed_rows.push_back('{lo: 33'd5400000001, typed: 1'b1, want: error_result()});
        directed_rows.push_back('{lo: 33'h1_FFFF_FFFF, typed: 1'b1, want: error_result()});
        directed_rows.push_back('{lo: 33'd5400000000, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd5400000000, typed: 1'b1,
                                  want: skipped_result(33'd5400000000)});
        directed_rows.push_back('{lo: 33'd1, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd0, typed: 1'b1, want: error_result()});
        directed_rows.push_back('{lo: 33'd1, typed: 1'b1, want: skipped_result(33'd1)});
        directed_rows.push_back('{lo: 33'd2400000000, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd1600000000, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd3200000001, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd3200000000, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd42187500, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd84375001, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd2600000000, typed: 1'b0, want: '0});
        directed_rows.push_back('{lo: 33'd2600000000, typed: 1'b1,
                                  want: skipped_result(33'd2600000000)});
        directed_rows.push_back('{lo: 33'd0, typed: 1'b1, want: error_result()});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.lo, row.typed, row.want);
        end
        wait_for_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase_drawn[phase]) begin
                phase_ref[phase]    = fnpll_pkg::LO_W'($urandom_range(10000000, 104000000));
                phase_lo_max[phase] = fnpll_pkg::LO_W'(64'd1000000000 +
                                          ({$urandom, $urandom} % 64'd5000000001));
            end
            if (phase != 0)
                load_settings(phase_ref[phase], phase_lo_max[phase]);

            // Phase 2 starts with both sides running flat out.
            idle_on = (phase != 2);
            for (int item = 0; item < phase_items[phase]; item++) begin
                if (item % 50 == 49)
                    idle_on = ($urandom_range(0, 3) != 0);
                // Hold off the sender before item 100 until the block is empty.
                if (item == 100)
                    wait_for_results();
                send_request(draw_request(), 1'b0, '0);
            end
            wait_for_results();
        end

        // Give any spurious extra result time to show up.
        repeat (100) @(posedge i_clk);
        if (pending_tunings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_tunings.size()));

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
